### hdl/rrk4_pkg.sv
// Shared types, constants and micro-program for the Rossler RK4 integrator.
// Used by rrk4_seq, rrk4_unit and rossler_rk4_integrator; depends on nothing.
package rrk4_pkg;

	localparam int WORD_W       = 32;
	localparam int DT_W         = 31;
	localparam int SIXTH_W      = 29;
	localparam int OPND_W       = 33;
	localparam int SUM_W        = 35;
	localparam int PROD_W       = 66;
	localparam int ACC_W        = 64;
	localparam int RECIP6_SHIFT = 34;
	localparam logic [WORD_W-1:0] RECIP6 = 32'hAAAAAAAB;

	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] PC_PRO      = 5'd0;
	localparam logic [PC_W-1:0] PC_BODY     = 5'd2;
	localparam logic [PC_W-1:0] PC_LAST_ACC = 5'd15;
	localparam logic [PC_W-1:0] PC_BODY_END = 5'd24;
	localparam logic [PC_W-1:0] PC_FINAL    = 5'd25;
	localparam logic [PC_W-1:0] PC_LAST     = 5'd30;

	typedef enum logic [0:0] {
		ITEM_LOAD = 1'b0,
		ITEM_STEP = 1'b1
	} item_op_t;

	typedef enum logic [1:0] {
		REG_COEF_A    = 2'd0,
		REG_COEF_B    = 2'd1,
		REG_COEF_C    = 2'd2,
		REG_TIME_STEP = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		UOP_NOP,
		UOP_MUL,
		UOP_ADD,
		UOP_RND,
		UOP_RACC,
		UOP_ACC,
		UOP_SIXTH
	} uop_op_t;

	typedef enum logic [4:0] {
		SRC_ZERO,
		SRC_VX,
		SRC_VY,
		SRC_VZ,
		SRC_PX,
		SRC_PY,
		SRC_PZ,
		SRC_KX,
		SRC_KY,
		SRC_KZ,
		SRC_T,
		SRC_CA,
		SRC_CB,
		SRC_CC,
		SRC_DT,
		SRC_DT3,
		SRC_RECIP6,
		SRC_SIXTH
	} src_t;

	typedef enum logic [3:0] {
		DST_NONE,
		DST_T,
		DST_KX,
		DST_KY,
		DST_KZ,
		DST_QX,
		DST_QY,
		DST_QZ,
		DST_PX,
		DST_PY,
		DST_PZ
	} dst_t;

	typedef struct packed {
		uop_op_t    op;
		src_t       src_a;
		src_t       src_b;
		logic       neg_a;
		logic       neg_b;
		dst_t       dst;
		logic [1:0] lane;
		logic       stage_shift;
	} uop_t;

	typedef struct packed {
		logic en;
		logic clear;
		uop_t uop;
		logic use_q;
		logic half;
		logic acc_init;
		logic acc_dbl;
	} ctl_t;

	typedef struct packed {
		logic take;
		logic step;
		logic out_free;
	} req_t;

	typedef struct packed {
		logic idle;
		logic capture;
	} status_t;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              clip;
	} sat_t;

	function automatic sat_t sat_word(input logic signed [PROD_W-1:0] v);
		sat_t r;
		if ((&v[PROD_W-1:WORD_W-1]) || !(|v[PROD_W-1:WORD_W-1])) begin
			r.value = v[WORD_W-1:0];
			r.clip  = 1'b0;
		end else begin
			r.value = v[PROD_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
			r.clip  = 1'b1;
		end
		return r;
	endfunction

	function automatic uop_t mk(input uop_op_t op, input src_t a, input src_t b,
			input logic na, input logic nb, input dst_t d, input logic [1:0] lane,
			input logic stg);
		uop_t r;
		r.op          = op;
		r.src_a       = a;
		r.src_b       = b;
		r.neg_a       = na;
		r.neg_b       = nb;
		r.dst         = d;
		r.lane        = lane;
		r.stage_shift = stg;
		return r;
	endfunction

	function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
		uop_t r;
		case (pc)
			5'd0:  r = mk(UOP_MUL,   SRC_DT3, SRC_RECIP6, 1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
			5'd1:  r = mk(UOP_SIXTH, SRC_ZERO, SRC_ZERO,  1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
			5'd2:  r = mk(UOP_ADD,   SRC_VY,  SRC_VZ,     1'b1, 1'b1, DST_KX,   2'd0, 1'b0);
			5'd3:  r = mk(UOP_MUL,   SRC_CA,  SRC_VY,     1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
			5'd4:  r = mk(UOP_RND,   SRC_ZERO, SRC_ZERO,  1'b0, 1'b0, DST_T,    2'd0, 1'b0);
			5'd5:  r = mk(UOP_ADD,   SRC_VX,  SRC_T,      1'b0, 1'b0, DST_KY,   2'd0, 1'b0);
			5'd6:  r = mk(UOP_ADD,   SRC_VX,  SRC_CC,     1'b0, 1'b1, DST_T,    2'd0, 1'b0);
			5'd7:  r = mk(UOP_MUL,   SRC_VZ,  SRC_T,      1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
			5'd8:  r = mk(UOP_RND,   SRC_ZERO, SRC_ZERO,  1'b0, 1'b0, DST_T,    2'd0, 1'b0);
			5'd9:  r = mk(UOP_ADD,   SRC_CB,  SRC_T,      1'b0, 1'b0, DST_KZ,   2'd0, 1'b0);
			5'd10: r = mk(UOP_MUL,   SRC_KX,  SRC_SIXTH,  1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
			5'd11: r = mk(UOP_ACC,   SRC_ZERO, SRC_ZERO,  1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
			5'd12: r = mk(UOP_MUL,   SRC_KY,  SRC_SIXTH,  1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
			5'd13: r = mk(UOP_ACC,   SRC_ZERO, SRC_ZERO,  1'b0, 1'b0, DST_NONE, 2'd1, 1'b0);
			5'd14: r = mk(UOP_MUL,   SRC_KZ,  SRC_SIXTH,  1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
			5'd15: r = mk(UOP_ACC,   SRC_ZERO, SRC_ZERO,  1'b0, 1'b0, DST_NONE, 2'd2, 1'b0);
			5'd16: r = mk(UOP_MUL,   SRC_DT,  SRC_KX,     1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
			5'd17: r = mk(UOP_RND,   SRC_ZERO, SRC_ZERO,  1'b0, 1'b0, DST_T,    2'd0, 1'b1);
			5'd18: r = mk(UOP_ADD,   SRC_PX,  SRC_T,      1'b0, 1'b0, DST_QX,   2'd0, 1'b0);
			5'd19: r = mk(UOP_MUL,   SRC_DT,  SRC_KY,     1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
			5'd20: r = mk(UOP_RND,   SRC_ZERO, SRC_ZERO,  1'b0, 1'b0, DST_T,    2'd0, 1'b1);
			5'd21: r = mk(UOP_ADD,   SRC_PY,  SRC_T,      1'b0, 1'b0, DST_QY,   2'd0, 1'b0);
			5'd22: r = mk(UOP_MUL,   SRC_DT,  SRC_KZ,     1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
			5'd23: r = mk(UOP_RND,   SRC_ZERO, SRC_ZERO,  1'b0, 1'b0, DST_T,    2'd0, 1'b1);
			5'd24: r = mk(UOP_ADD,   SRC_PZ,  SRC_T,      1'b0, 1'b0, DST_QZ,   2'd0, 1'b0);
			5'd25: r = mk(UOP_RACC,  SRC_ZERO, SRC_ZERO,  1'b0, 1'b0, DST_T,    2'd0, 1'b0);
			5'd26: r = mk(UOP_ADD,   SRC_PX,  SRC_T,      1'b0, 1'b0, DST_PX,   2'd0, 1'b0);
			5'd27: r = mk(UOP_RACC,  SRC_ZERO, SRC_ZERO,  1'b0, 1'b0, DST_T,    2'd1, 1'b0);
			5'd28: r = mk(UOP_ADD,   SRC_PY,  SRC_T,      1'b0, 1'b0, DST_PY,   2'd0, 1'b0);
			5'd29: r = mk(UOP_RACC,  SRC_ZERO, SRC_ZERO,  1'b0, 1'b0, DST_T,    2'd2, 1'b0);
			5'd30: r = mk(UOP_ADD,   SRC_PZ,  SRC_T,      1'b0, 1'b0, DST_PZ,   2'd0, 1'b0);
			default: r = mk(UOP_NOP, SRC_ZERO, SRC_ZERO,  1'b0, 1'b0, DST_NONE, 2'd0, 1'b0);
		endcase
		return r;
	endfunction

endpackage

### hdl/rossler_rk4_integrator.sv
// Top level of the Rossler RK4 integrator: configuration registers, handshakes,
// result register. Depends on rrk4_pkg, rrk4_seq and rrk4_unit.
//
// The block holds one point (x, y, z) in signed fixed point with FRAC_BITS
// fraction bits. A load transaction (operation 0) replaces the point. A step
// transaction (operation 1) runs 91 micro-ops on one shared 33x33 multiplier
// and saturating adder: two to form dt/6, 23 for each of the first three RK4
// stages, 14 for the fourth, six for the final update. Either result enters
// the output register once that register is free. in_stall is high from
// acceptance until the result enters the output register, so items are
// worked one at a time; the output register lets a new item start while the
// previous result waits.
// Registers on the APB port: 0x0 coef_a, 0x4 coef_b, 0x8 coef_c,
// 0xC time_step (31 bits); write only while the block is idle.
module rossler_rk4_integrator #(
	parameter int FRAC_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [3:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic signed [rrk4_pkg::WORD_W-1:0]  load_x,
	input  logic signed [rrk4_pkg::WORD_W-1:0]  load_y,
	input  logic signed [rrk4_pkg::WORD_W-1:0]  load_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [rrk4_pkg::WORD_W-1:0]  out_x,
	output logic signed [rrk4_pkg::WORD_W-1:0]  out_y,
	output logic signed [rrk4_pkg::WORD_W-1:0]  out_z,
	output logic                                saturated
);
	import rrk4_pkg::*;

	localparam logic [63:0] ONE2 = 64'd1 << (FRAC_BITS + 1);
	localparam logic [WORD_W-1:0] COEF_AB_RST = WORD_W'((ONE2 + 64'd5) / 64'd10);
	localparam logic [WORD_W-1:0] COEF_C_RST  = WORD_W'((64'd57 * ONE2 + 64'd10) / 64'd20);
	localparam logic [DT_W-1:0]   DT_RST      = DT_W'((ONE2 + 64'd200) / 64'd400);

	logic signed [WORD_W-1:0] coef_a_q, coef_b_q, coef_c_q;
	logic        [DT_W-1:0]   time_step_q;
	logic signed [WORD_W-1:0] out_x_q, out_y_q, out_z_q;
	logic                     out_sat_q;
	logic                     out_valid_q;

	logic                     cfg_wr;
	reg_idx_t                 reg_idx;
	req_t                     req;
	ctl_t                     ctl;
	status_t                  status;
	logic                     take;
	logic signed [WORD_W-1:0] point_x, point_y, point_z;
	logic                     point_sat;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (reg_idx)
			REG_COEF_A:    prdata = coef_a_q;
			REG_COEF_B:    prdata = coef_b_q;
			REG_COEF_C:    prdata = coef_c_q;
			REG_TIME_STEP: prdata = {1'b0, time_step_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q    <= COEF_AB_RST;
			coef_b_q    <= COEF_AB_RST;
			coef_c_q    <= COEF_C_RST;
			time_step_q <= DT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_COEF_A:    coef_a_q    <= pwdata;
				REG_COEF_B:    coef_b_q    <= pwdata;
				REG_COEF_C:    coef_c_q    <= pwdata;
				REG_TIME_STEP: time_step_q <= pwdata[DT_W-1:0];
				default:       ;
			endcase
		end
	end

	assign in_stall     = !status.idle;
	assign take         = in_valid && !in_stall;
	assign req.take     = take;
	assign req.step     = (item_op_t'(operation) == ITEM_STEP);
	assign req.out_free = !out_valid_q || !out_stall;

	rrk4_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.status (status)
	);

	rrk4_unit #(
		.FRAC_BITS (FRAC_BITS)
	) u_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.coef_a    (coef_a_q),
		.coef_b    (coef_b_q),
		.coef_c    (coef_c_q),
		.time_step (time_step_q),
		.load      (take && !req.step),
		.load_x    (load_x),
		.load_y    (load_y),
		.load_z    (load_z),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.saturated (point_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (status.capture) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.capture) begin
			out_x_q   <= point_x;
			out_y_q   <= point_y;
			out_z_q   <= point_z;
			out_sat_q <= point_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;
	assign saturated = out_sat_q;

endmodule

### hdl/rrk4_seq.sv
// Micro-program sequencer: item state machine, program counter and RK4 stage count.
// Depends on rrk4_pkg for the micro-op table and the control structs.
module rrk4_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  rrk4_pkg::req_t    req,
	output rrk4_pkg::ctl_t    ctl,
	output rrk4_pkg::status_t status
);
	import rrk4_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [PC_W-1:0]   pc_q;
	logic [1:0]        stage_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.take) begin
					state_d = req.step ? S_RUN : S_DONE;
				end
			end
			S_RUN: begin
				if (pc_q == PC_LAST) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (req.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		status.idle    = (state_q == S_IDLE);
		status.capture = (state_q == S_DONE) && req.out_free;
		ctl.en         = (state_q == S_RUN);
		ctl.clear      = req.take;
		ctl.uop        = uop_rom(pc_q);
		ctl.use_q      = (stage_q != 2'd0);
		ctl.half       = ctl.uop.stage_shift && (stage_q < 2'd2);
		ctl.acc_init   = (stage_q == 2'd0);
		ctl.acc_dbl    = (stage_q == 2'd1) || (stage_q == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= PC_PRO;
			stage_q <= 2'd0;
		end else begin
			state_q <= state_d;
			if (req.take) begin
				pc_q    <= PC_PRO;
				stage_q <= 2'd0;
			end else if (state_q == S_RUN) begin
				if (pc_q == PC_LAST_ACC && stage_q == 2'd3) begin
					pc_q <= PC_FINAL;
				end else if (pc_q == PC_BODY_END) begin
					pc_q    <= PC_BODY;
					stage_q <= stage_q + 2'd1;
				end else if (pc_q != PC_LAST) begin
					pc_q <= pc_q + PC_W'(1);
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pc_q <= PC_LAST)
		else $error("program counter beyond last micro-op");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && stage_q == 2'd3) |-> (pc_q <= PC_LAST_ACC || pc_q >= PC_FINAL))
		else $error("stage-point update issued in last RK4 stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && pc_q == PC_LAST) |=> (state_q == S_DONE))
		else $error("step did not finish after last micro-op");

	assert property (@(posedge clk) disable iff (!arst_n)
		(req.take && req.step) |=> (state_q == S_RUN && pc_q == PC_PRO && stage_q == 2'd0))
		else $error("step transaction did not start the program");

endmodule

### hdl/rrk4_unit.sv
// Shared arithmetic unit: one 33x33 multiplier, one saturating adder and rounder,
// and the point, stage, slope and accumulator registers. Depends on rrk4_pkg.
module rrk4_unit #(
	parameter int FRAC_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rrk4_pkg::ctl_t                      ctl,
	input  logic signed [rrk4_pkg::WORD_W-1:0]  coef_a,
	input  logic signed [rrk4_pkg::WORD_W-1:0]  coef_b,
	input  logic signed [rrk4_pkg::WORD_W-1:0]  coef_c,
	input  logic        [rrk4_pkg::DT_W-1:0]    time_step,
	input  logic                                load,
	input  logic signed [rrk4_pkg::WORD_W-1:0]  load_x,
	input  logic signed [rrk4_pkg::WORD_W-1:0]  load_y,
	input  logic signed [rrk4_pkg::WORD_W-1:0]  load_z,
	output logic signed [rrk4_pkg::WORD_W-1:0]  point_x,
	output logic signed [rrk4_pkg::WORD_W-1:0]  point_y,
	output logic signed [rrk4_pkg::WORD_W-1:0]  point_z,
	output logic                                saturated
);
	import rrk4_pkg::*;

	logic signed [WORD_W-1:0] px_q, py_q, pz_q;
	logic signed [WORD_W-1:0] qx_q, qy_q, qz_q;
	logic signed [WORD_W-1:0] kx_q, ky_q, kz_q;
	logic signed [WORD_W-1:0] t_q;
	logic signed [ACC_W-1:0]  accx_q, accy_q, accz_q;
	logic        [SIXTH_W-1:0] sixth_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     sat_q;

	logic signed [WORD_W-1:0] vx, vy, vz;
	logic        [WORD_W-1:0] dt3;
	logic signed [OPND_W-1:0] opa, opb;
	logic signed [PROD_W-1:0] prod_w;
	logic signed [SUM_W-1:0]  a_ext, b_ext, sum_w;
	logic signed [ACC_W-1:0]  acc_sel, acc_add;
	logic signed [PROD_W-1:0] rnd_src, rnd_w, sat_in;
	sat_t                     res;
	logic                     wr_en;

	always_comb begin
		vx  = ctl.use_q ? qx_q : px_q;
		vy  = ctl.use_q ? qy_q : py_q;
		vz  = ctl.use_q ? qz_q : pz_q;
		dt3 = {1'b0, time_step} + 32'd3;
	end

	always_comb begin
		case (ctl.uop.src_a)
			SRC_VX:     opa = {vx[WORD_W-1], vx};
			SRC_VY:     opa = {vy[WORD_W-1], vy};
			SRC_VZ:     opa = {vz[WORD_W-1], vz};
			SRC_PX:     opa = {px_q[WORD_W-1], px_q};
			SRC_PY:     opa = {py_q[WORD_W-1], py_q};
			SRC_PZ:     opa = {pz_q[WORD_W-1], pz_q};
			SRC_KX:     opa = {kx_q[WORD_W-1], kx_q};
			SRC_KY:     opa = {ky_q[WORD_W-1], ky_q};
			SRC_KZ:     opa = {kz_q[WORD_W-1], kz_q};
			SRC_T:      opa = {t_q[WORD_W-1], t_q};
			SRC_CA:     opa = {coef_a[WORD_W-1], coef_a};
			SRC_CB:     opa = {coef_b[WORD_W-1], coef_b};
			SRC_CC:     opa = {coef_c[WORD_W-1], coef_c};
			SRC_DT:     opa = {{(OPND_W-DT_W){1'b0}}, time_step};
			SRC_DT3:    opa = {1'b0, dt3};
			SRC_RECIP6: opa = {1'b0, RECIP6};
			SRC_SIXTH:  opa = {{(OPND_W-SIXTH_W){1'b0}}, sixth_q};
			default:    opa = '0;
		endcase
		case (ctl.uop.src_b)
			SRC_VX:     opb = {vx[WORD_W-1], vx};
			SRC_VY:     opb = {vy[WORD_W-1], vy};
			SRC_VZ:     opb = {vz[WORD_W-1], vz};
			SRC_PX:     opb = {px_q[WORD_W-1], px_q};
			SRC_PY:     opb = {py_q[WORD_W-1], py_q};
			SRC_PZ:     opb = {pz_q[WORD_W-1], pz_q};
			SRC_KX:     opb = {kx_q[WORD_W-1], kx_q};
			SRC_KY:     opb = {ky_q[WORD_W-1], ky_q};
			SRC_KZ:     opb = {kz_q[WORD_W-1], kz_q};
			SRC_T:      opb = {t_q[WORD_W-1], t_q};
			SRC_CA:     opb = {coef_a[WORD_W-1], coef_a};
			SRC_CB:     opb = {coef_b[WORD_W-1], coef_b};
			SRC_CC:     opb = {coef_c[WORD_W-1], coef_c};
			SRC_DT:     opb = {{(OPND_W-DT_W){1'b0}}, time_step};
			SRC_DT3:    opb = {1'b0, dt3};
			SRC_RECIP6: opb = {1'b0, RECIP6};
			SRC_SIXTH:  opb = {{(OPND_W-SIXTH_W){1'b0}}, sixth_q};
			default:    opb = '0;
		endcase
	end

	always_comb begin
		prod_w = opa * opb;
		a_ext  = {{(SUM_W-OPND_W){opa[OPND_W-1]}}, opa};
		b_ext  = {{(SUM_W-OPND_W){opb[OPND_W-1]}}, opb};
		sum_w  = (ctl.uop.neg_a ? -a_ext : a_ext) + (ctl.uop.neg_b ? -b_ext : b_ext);
		case (ctl.uop.lane)
			2'd0:    acc_sel = accx_q;
			2'd1:    acc_sel = accy_q;
			default: acc_sel = accz_q;
		endcase
		acc_add = ctl.acc_dbl ? {prod_q[ACC_W-2:0], 1'b0} : prod_q[ACC_W-1:0];
		rnd_src = (ctl.uop.op == UOP_RACC) ?
			{{(PROD_W-ACC_W){acc_sel[ACC_W-1]}}, acc_sel} : prod_q;
		if (ctl.half) begin
			rnd_w = (rnd_src + (PROD_W'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
		end else begin
			rnd_w = (rnd_src + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		end
		sat_in = (ctl.uop.op == UOP_ADD) ? {{(PROD_W-SUM_W){sum_w[SUM_W-1]}}, sum_w} : rnd_w;
		res    = sat_word(sat_in);
		wr_en  = ctl.en && (ctl.uop.op inside {UOP_ADD, UOP_RND, UOP_RACC});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q  <= '0;
			py_q  <= '0;
			pz_q  <= '0;
			sat_q <= 1'b0;
		end else begin
			if (load) begin
				px_q <= load_x;
				py_q <= load_y;
				pz_q <= load_z;
			end else if (wr_en) begin
				case (ctl.uop.dst)
					DST_PX:  px_q <= res.value;
					DST_PY:  py_q <= res.value;
					DST_PZ:  pz_q <= res.value;
					default: ;
				endcase
			end
			if (ctl.clear) begin
				sat_q <= 1'b0;
			end else if (wr_en && res.clip) begin
				sat_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (ctl.uop.dst)
				DST_T:   t_q  <= res.value;
				DST_KX:  kx_q <= res.value;
				DST_KY:  ky_q <= res.value;
				DST_KZ:  kz_q <= res.value;
				DST_QX:  qx_q <= res.value;
				DST_QY:  qy_q <= res.value;
				DST_QZ:  qz_q <= res.value;
				default: ;
			endcase
		end
		if (ctl.en && ctl.uop.op == UOP_MUL) begin
			prod_q <= prod_w;
		end
		if (ctl.en && ctl.uop.op == UOP_SIXTH) begin
			sixth_q <= prod_q[RECIP6_SHIFT +: SIXTH_W];
		end
		if (ctl.en && ctl.uop.op == UOP_ACC) begin
			case (ctl.uop.lane)
				2'd0:    accx_q <= ctl.acc_init ? acc_add : accx_q + acc_add;
				2'd1:    accy_q <= ctl.acc_init ? acc_add : accy_q + acc_add;
				default: accz_q <= ctl.acc_init ? acc_add : accz_q + acc_add;
			endcase
		end
	end

	assign point_x   = px_q;
	assign point_y   = py_q;
	assign point_z   = pz_q;
	assign saturated = sat_q;

endmodule

### dv/tb_rossler_rk4_integrator.sv
// Self-checking testbench for rossler_rk4_integrator: directed and random load/step
// transactions under several APB coefficient settings, with random idling and back-pressure.
// Depends on rrk4_pkg and the integrator RTL; expected points come from an RK4 predictor here.
module tb_rossler_rk4_integrator;
	import rrk4_pkg::*;

	localparam int          FRAC        = 24;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam longint      WORD_MAX    = 64'sd2147483647;
	localparam longint      WORD_MIN    = -64'sd2147483648;
	localparam logic [31:0] DEF_AB      = 32'd3355443;
	localparam logic [31:0] DEF_C       = 32'd95630131;
	localparam logic [31:0] DEF_DT      = 32'd83886;
	localparam logic [31:0] FX_ONE      = 32'h0100_0000;
	localparam int unsigned PT_SPAN     = 32'h1000_0000;
	localparam int unsigned COEF_SPAN   = 32'h0080_0000;

	typedef longint vec3_t [3];
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        sat;
	} point_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic               operation;
	logic signed [31:0] load_x;
	logic signed [31:0] load_y;
	logic signed [31:0] load_z;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic               saturated;

	longint      coef_a_m;
	longint      coef_b_m;
	longint      coef_c_m;
	longint      dt_m;
	vec3_t       orbit_pt;
	bit          clip_seen;
	point_t      expected_points[$];
	int          failures;
	int          load_count;
	int          step_count;
	int          setting_count;
	int          result_count;
	int          sat_count;
	int unsigned cycle_count;
	bit          tx_gaps;
	bit          rx_gaps;
	int          rx_hold_req;

	rossler_rk4_integrator i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp_word(input longint v);
		if (v > WORD_MAX) begin
			clip_seen = 1'b1;
			return WORD_MAX;
		end
		if (v < WORD_MIN) begin
			clip_seen = 1'b1;
			return WORD_MIN;
		end
		return v;
	endfunction

	function automatic longint round_half_up(input longint v, input int s);
		return (v + (64'sd1 << (s - 1))) >>> s;
	endfunction

	function automatic longint fx_mul(input longint a, input longint b);
		return clamp_word(round_half_up(a * b, FRAC));
	endfunction

	function automatic vec3_t rossler_slope(input vec3_t v);
		vec3_t d;
		d[0] = clamp_word(-v[1] - v[2]);
		d[1] = clamp_word(v[0] + fx_mul(coef_a_m, v[1]));
		d[2] = clamp_word(coef_b_m + fx_mul(v[2], clamp_word(v[0] - coef_c_m)));
		return d;
	endfunction

	function automatic vec3_t euler_point(input vec3_t p, input vec3_t k, input int s);
		vec3_t q;
		int    i;
		for (i = 0; i < 3; i++)
			q[i] = clamp_word(p[i] + clamp_word(round_half_up(dt_m * k[i], s)));
		return q;
	endfunction

	function automatic void rk4_advance();
		vec3_t  k1, k2, k3, k4, q;
		longint sixth, total;
		int     i;
		sixth = (dt_m + 3) / 6;
		k1 = rossler_slope(orbit_pt);
		q  = euler_point(orbit_pt, k1, FRAC + 1);
		k2 = rossler_slope(q);
		q  = euler_point(orbit_pt, k2, FRAC + 1);
		k3 = rossler_slope(q);
		q  = euler_point(orbit_pt, k3, FRAC);
		k4 = rossler_slope(q);
		for (i = 0; i < 3; i++) begin
			total = k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i];
			orbit_pt[i] = clamp_word(orbit_pt[i] +
				clamp_word(round_half_up(total * sixth, FRAC)));
		end
	endfunction

	function automatic void predict_point(input item_op_t op, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z);
		point_t e;
		clip_seen = 1'b0;
		if (op == ITEM_LOAD) begin
			orbit_pt[0] = x;
			orbit_pt[1] = y;
			orbit_pt[2] = z;
			load_count++;
		end else begin
			rk4_advance();
			step_count++;
		end
		e.x   = orbit_pt[0][31:0];
		e.y   = orbit_pt[1][31:0];
		e.z   = orbit_pt[2][31:0];
		e.sat = clip_seen;
		expected_points.push_back(e);
	endfunction

	function automatic logic [31:0] rand_span(input int unsigned span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	// receiver: random stall bursts, plus a long hold-off on request
	initial begin
		int burst;
		out_stall = 1'b0;
		burst = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				burst = rx_hold_req;
				rx_hold_req = 0;
				out_stall <= 1'b1;
				repeat (burst - 1) @(negedge clk);
				burst = 0;
			end else if (burst > 0) begin
				out_stall <= 1'b1;
				burst--;
			end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				burst = $urandom_range(1, 17) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		point_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_points.size() == 0) begin
				$error("result with no transaction pending: x=%h y=%h z=%h", out_x, out_y,
					out_z);
				failures++;
			end else begin
				want = expected_points.pop_front();
				result_count++;
				if (want.sat)
					sat_count++;
				if (out_x !== want.x) begin
					$error("out_x: expected %h, actual %h", want.x, out_x);
					failures++;
				end
				if (out_y !== want.y) begin
					$error("out_y: expected %h, actual %h", want.y, out_y);
					failures++;
				end
				if (out_z !== want.z) begin
					$error("out_z: expected %h, actual %h", want.z, out_z);
					failures++;
				end
				if (saturated !== want.sat) begin
					$error("saturated: expected %b, actual %b", want.sat, saturated);
					failures++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
			expected_points.size());
		$display("FAILURE");
		$finish;
	end

	task automatic send_item(input item_op_t op, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		int gap;
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 17);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		operation <= op;
		load_x    <= x;
		load_y    <= y;
		load_z    <= z;
		do @(posedge clk); while (in_stall);
		predict_point(op, x, y, z);
	endtask

	task automatic send_step();
		send_item(ITEM_STEP, $urandom, $urandom, $urandom);
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (expected_points.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_orbit(input int steps);
		send_item(ITEM_LOAD, rand_span(PT_SPAN), rand_span(PT_SPAN), rand_span(PT_SPAN));
		repeat (steps) send_step();
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_COEF_A:    coef_a_m = longint'($signed(value));
			REG_COEF_B:    coef_b_m = longint'($signed(value));
			REG_COEF_C:    coef_c_m = longint'($signed(value));
			REG_TIME_STEP: dt_m     = longint'(value[30:0]);
			default: ;
		endcase
	endtask

	task automatic program_setting(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] dt);
		idle_input();
		drain();
		write_reg(REG_COEF_A, a);
		write_reg(REG_COEF_B, b);
		write_reg(REG_COEF_C, c);
		write_reg(REG_TIME_STEP, dt);
		setting_count++;
	endtask

	task automatic program_random_setting();
		logic [31:0] dt;
		dt = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 838860);
		program_setting(rand_span(COEF_SPAN), rand_span(COEF_SPAN),
			$urandom_range(0, 32'h1000_0000), dt);
	endtask

	// reset point and default coefficients, then extreme points
	task automatic test_reset_and_extremes();
		send_step();
		send_item(ITEM_LOAD, FX_ONE, FX_ONE, FX_ONE);
		repeat (3) send_step();
		send_item(ITEM_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_step();
		send_item(ITEM_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_step();
		send_item(ITEM_LOAD, 32'd0, 32'd0, 32'd0);
		send_item(ITEM_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
		send_step();
		send_item(ITEM_LOAD, 32'hFFFF_FFFF, 32'd0, 32'd1);
		send_step();
		send_item(ITEM_LOAD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
		send_step();
		idle_input();
	endtask

	task automatic test_register_extremes();
		program_setting(DEF_AB, DEF_AB, DEF_C, 32'd0);
		run_orbit(6);
		program_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		run_orbit(8);
		send_item(ITEM_LOAD, $urandom, $urandom, $urandom);
		send_step();
		program_setting(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0003);
		run_orbit(8);
		program_setting(32'd0, 32'd0, 32'd0, FX_ONE);
		run_orbit(10);
		program_setting(rand_span(COEF_SPAN), rand_span(COEF_SPAN), $urandom,
			32'h8000_0000 | $urandom_range(1, 838860));
		run_orbit(15);
		program_setting(DEF_AB, DEF_AB, DEF_C, DEF_DT);
		run_orbit(12);
		idle_input();
	endtask

	task automatic test_random_orbits(input int quota);
		int start;
		int orbits;
		start = load_count + step_count;
		orbits = 0;
		while (load_count + step_count - start < quota) begin
			if (orbits % 8 == 0)
				program_random_setting();
			orbits++;
			if ($urandom_range(0, 99) < 85) begin
				run_orbit($urandom_range(4, 25));
			end else begin
				repeat ($urandom_range(1, 3))
					send_item($urandom_range(0, 1) ? ITEM_STEP : ITEM_LOAD,
						$urandom, $urandom, $urandom);
			end
		end
		idle_input();
	endtask

	// hold the receiver while the sender keeps offering, then pause until drained
	task automatic test_backpressure();
		program_setting(DEF_AB, DEF_AB, DEF_C, DEF_DT);
		rx_hold_req = 300;
		run_orbit(7);
		idle_input();
		drain();
		run_orbit(10);
		idle_input();
	endtask

	task automatic test_steady_tail();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		program_random_setting();
		run_orbit(30);
		program_setting(DEF_AB, DEF_AB, DEF_C, DEF_DT);
		run_orbit(35);
		idle_input();
	endtask

	initial begin
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		operation = ITEM_LOAD;
		load_x    = '0;
		load_y    = '0;
		load_z    = '0;
		tx_gaps   = 1'b1;
		rx_gaps   = 1'b1;
		rx_hold_req = 0;
		failures = 0;
		load_count = 0;
		step_count = 0;
		setting_count = 0;
		result_count = 0;
		sat_count = 0;
		coef_a_m = longint'(DEF_AB);
		coef_b_m = longint'(DEF_AB);
		coef_c_m = longint'(DEF_C);
		dt_m     = longint'(DEF_DT);
		orbit_pt = '{0, 0, 0};
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_and_extremes();
		test_register_extremes();
		test_random_orbits(440);
		test_backpressure();
		test_steady_tail();

		drain();
		repeat (100) @(posedge clk);
		$display("Ran %0d loads and %0d RK4 steps under %0d coefficient settings;",
			load_count, step_count, setting_count);
		$display("%0d points checked, %0d of them with clipping, %0d mismatches.",
			result_count, sat_count, failures);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
